@@ src/line_to_quad_expand_defines.svh @@
// assertion macros shared by the checker
// no dependencies
`ifndef LINE_TO_QUAD_EXPAND_DEFINES_SVH
`define LINE_TO_QUAD_EXPAND_DEFINES_SVH
// property that must hold on every clock edge outside reset
`define LQE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("lqe check failed");
// property that must hold in the cycle after a trigger
`define LQE_ASSERT_NEXT(lbl, trig, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error("lqe check failed");
`endif

@@ src/lqe_pkg.sv @@
// shared types and constants for the line to quad expander
// no dependencies
`default_nettype none
package lqe_pkg;
    localparam logic OP_LINE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;
    localparam logic KIND_VERT = 1'b0;
    localparam logic KIND_IDX  = 1'b1;
    localparam int   QDEPTH = 2;

    // command handed from front to back
    typedef struct packed {
        logic               clear;
        logic signed [31:0] sx, sy, sz, ex, ey, ez;
        logic [31:0]        w, rgba;
    } cmd_t;
endpackage
`default_nettype wire

@@ src/lqe_front.sv @@
// front end: accepts command items and queues them
// depends on lqe_pkg
`default_nettype none
module lqe_front (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               in_valid,
    output logic              in_ready,
    input  lqe_pkg::cmd_t     in_cmd,
    output logic              q_valid,
    input  wire               q_pop,
    output lqe_pkg::cmd_t     q_cmd
);
    lqe_pkg::cmd_t mem_reg [lqe_pkg::QDEPTH];
    logic       wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];

    // pointer update
    always_comb begin
        wp_next  = wp_reg + 1'b1;
        rp_next  = rp_reg + 1'b1;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= wp_next;
            if (q_pop && q_valid) rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_cmd;
    end
endmodule
`default_nettype wire

@@ src/lqe_back.sv @@
// back end: direction, side vector, vertex and index emission
// depends on lqe_pkg
`default_nettype none
module lqe_back (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              q_valid,
    output logic             q_pop,
    input  lqe_pkg::cmd_t    q_cmd,
    output logic             m_valid,
    input  wire              m_ready,
    output logic [160:0]     m_data,
    output logic             m_last
);
    localparam logic [3:0] S_IDLE = 4'd0, S_NORM = 4'd1, S_SQRT = 4'd2, S_DIV = 4'd3,
        S_SIDE = 4'd4, S_MUL = 4'd5, S_OUT = 4'd6;

    logic [3:0]  st_reg;
    lqe_pkg::cmd_t c_reg;
    logic [32:0] m_reg [3];
    logic [2:0]  neg_reg;
    logic [63:0] rem_reg, root_reg;
    logic [5:0]  it_reg;
    logic [1:0]  ax_reg;
    logic [61:0] num_reg;
    logic [31:0] q_reg;
    logic [31:0] dir_reg [3];
    logic [31:0] rmag_reg [3];
    logic [2:0]  rneg_reg;
    logic [32:0] off_reg [3];
    logic [31:0] vc_reg;
    logic [3:0]  k_reg;
    logic [160:0] d_reg;
    logic        v_reg, l_reg;

    logic signed [33:0] dd [3];
    logic [32:0] mx;
    logic [63:0] sq, tb, rt;
    logic [63:0] prod;
    logic [63:0] div_try;
    logic        div_ge;
    logic [31:0] q_new;
    logic        busy_out;
    logic        load_out;

    assign busy_out = v_reg && !m_ready;
    assign load_out = (st_reg == S_OUT) && !busy_out;
    assign m_valid  = v_reg;
    assign m_data   = d_reg;
    assign m_last   = l_reg;
    assign q_pop    = (st_reg == S_IDLE) && q_valid;

    // differences of the queued command and the datapath terms of each state
    always_comb begin
        dd[0] = 34'(q_cmd.ex) - 34'(q_cmd.sx);
        dd[1] = 34'(q_cmd.ey) - 34'(q_cmd.sy);
        dd[2] = 34'(q_cmd.ez) - 34'(q_cmd.sz);
        mx = m_reg[0];
        if (m_reg[1] > mx) mx = m_reg[1];
        if (m_reg[2] > mx) mx = m_reg[2];
        sq = 64'(m_reg[ax_reg]) * 64'(m_reg[ax_reg]);
        tb = 64'd1 << {it_reg, 1'b0};
        rt = root_reg | tb;
        prod = 64'(rmag_reg[ax_reg]) * 64'(c_reg.w);
        div_try = {rem_reg[62:0], num_reg[61]};
        div_ge  = (div_try >= root_reg);
        q_new   = {q_reg[30:0], div_ge};
    end

    // signed saturating vertex coordinate
    function automatic logic [31:0] vtx(input logic signed [31:0] p, input logic [32:0] o,
                                        input logic ng, input logic sub);
        logic signed [34:0] s;
        logic signed [34:0] so;
        begin
            so = (ng ^ sub) ? -35'(o) : 35'(o);
            s  = 35'(p) + so;
            if (s > 35'sd2147483647) vtx = 32'h7fffffff;
            else if (s < -35'sd2147483648) vtx = 32'h80000000;
            else vtx = s[31:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            v_reg  <= 1'b0;
            vc_reg <= 32'd0;
            l_reg  <= 1'b0;
        end else begin
            // output register holds while stalled
            v_reg <= load_out || busy_out;
            unique case (st_reg)
                S_IDLE: if (q_valid) begin
                    c_reg <= q_cmd;
                    for (int i = 0; i < 3; i++) begin
                        m_reg[i]   <= dd[i][33] ? 33'(-dd[i]) : dd[i][32:0];
                        neg_reg[i] <= dd[i][33];
                    end
                    if (q_cmd.clear == lqe_pkg::OP_CLEAR) vc_reg <= 32'd0;
                    else if (dd[0] != 0 || dd[1] != 0 || dd[2] != 0) st_reg <= S_NORM;
                    ax_reg <= 2'd0;
                    rem_reg <= 64'd0;
                end
                // one shift step per cycle into [2^29, 2^30)
                S_NORM: begin
                    if (mx >= 33'h40000000) begin
                        for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] >> 1;
                    end else if (mx < 33'h20000000) begin
                        for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] << 1;
                    end else begin
                        // accumulate squares one axis a cycle
                        rem_reg <= rem_reg + sq;
                        if (ax_reg == 2'd2) begin
                            st_reg <= S_SQRT;
                            it_reg <= 6'd31;
                            root_reg <= 64'd0;
                        end
                        ax_reg <= ax_reg + 2'd1;
                    end
                end
                // bit-serial square root
                S_SQRT: begin
                    if (rem_reg >= rt) root_reg <= (root_reg >> 1) | tb;
                    else root_reg <= root_reg >> 1;
                    if (it_reg == 6'd0) begin
                        st_reg <= S_DIV;
                        ax_reg <= 2'd0;
                        it_reg <= 6'd61;
                        num_reg <= 62'(m_reg[0]) << 30;
                        rem_reg <= 64'd0;
                    end else begin
                        if (rem_reg >= rt) rem_reg <= rem_reg - rt;
                        it_reg <= it_reg - 6'd1;
                    end
                end
                // restoring division one bit a cycle
                S_DIV: begin
                    if (it_reg == 6'd0) begin
                        dir_reg[ax_reg] <= q_new;
                        rem_reg <= 64'd0;
                        it_reg  <= 6'd61;
                        if (ax_reg == 2'd2) st_reg <= S_SIDE;
                        else num_reg <= 62'(m_reg[ax_reg + 2'd1]) << 30;
                        ax_reg <= ax_reg + 2'd1;
                    end else begin
                        rem_reg <= div_ge ? div_try - root_reg : div_try;
                        q_reg   <= q_new;
                        num_reg <= num_reg << 1;
                        it_reg  <= it_reg - 6'd1;
                    end
                end
                // choose up vector, form side magnitudes
                S_SIDE: begin
                    if (36'(dir_reg[2]) * 36'd10 >= 36'd9 << 30) begin
                        rmag_reg[0] <= dir_reg[2]; rneg_reg[0] <= neg_reg[2];
                        rmag_reg[1] <= 32'd0;      rneg_reg[1] <= 1'b0;
                        rmag_reg[2] <= dir_reg[0]; rneg_reg[2] <= !neg_reg[0];
                    end else begin
                        rmag_reg[0] <= dir_reg[1]; rneg_reg[0] <= !neg_reg[1];
                        rmag_reg[1] <= dir_reg[0]; rneg_reg[1] <= neg_reg[0];
                        rmag_reg[2] <= 32'd0;      rneg_reg[2] <= 1'b0;
                    end
                    ax_reg <= 2'd0;
                    st_reg <= S_MUL;
                end
                // one width multiply per cycle
                S_MUL: begin
                    off_reg[ax_reg] <= 33'((prod + 64'd1073741824) >> 31);
                    if (ax_reg == 2'd2) begin
                        st_reg <= S_OUT;
                        k_reg  <= 4'd0;
                    end
                    ax_reg <= ax_reg + 2'd1;
                end
                // emit four vertices then six indices
                S_OUT: if (!busy_out) begin
                    l_reg <= (k_reg == 4'd9);
                    if (k_reg < 4'd4) begin
                        d_reg <= {32'd0, c_reg.rgba,
                            vtx(k_reg[1] ? c_reg.ez : c_reg.sz, off_reg[2], rneg_reg[2], k_reg[0]),
                            vtx(k_reg[1] ? c_reg.ey : c_reg.sy, off_reg[1], rneg_reg[1], k_reg[0]),
                            vtx(k_reg[1] ? c_reg.ex : c_reg.sx, off_reg[0], rneg_reg[0], k_reg[0]),
                            lqe_pkg::KIND_VERT};
                    end else begin
                        case (k_reg) inside
                            4'd4: d_reg <= {vc_reg, 128'd0, lqe_pkg::KIND_IDX};
                            4'd5, 4'd7: d_reg <= {vc_reg + 32'd1, 128'd0, lqe_pkg::KIND_IDX};
                            4'd8: d_reg <= {vc_reg + 32'd3, 128'd0, lqe_pkg::KIND_IDX};
                            default: d_reg <= {vc_reg + 32'd2, 128'd0, lqe_pkg::KIND_IDX};
                        endcase
                    end
                    k_reg <= k_reg + 4'd1;
                    if (k_reg == 4'd9) begin
                        vc_reg <= vc_reg + 32'd4;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ src/line_to_quad_expand.sv @@
// top level of the line to quad expander
// depends on lqe_pkg, lqe_front, lqe_back
`default_nettype none
// A draw item passes through the back end in order: it is taken in the idle
// state, then come up to 29 normalising shift steps and three squares, a
// 32-step square root, three 62-step serial divides in one shared divider, the
// choice of the side vector, three width multiplies, then ten results one per
// cycle while the result side does not stall. A clear item or a zero-length
// line is handled in the idle state, a clear also resetting the vertex count.
// A two-entry queue lets the input side take items while the back end works.
module line_to_quad_expand (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire [255:0]  s_tdata,  // start_x,start_y,start_z,end_x,end_y,end_z,line_width,rgba
    input  wire          s_tuser,  // opcode
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [159:0] m_tdata,  // vert_x,vert_y,vert_z,vert_rgba,tri_index
    output logic         m_tuser,  // kind
    output logic         m_tlast
);
    lqe_pkg::cmd_t in_cmd, q_cmd;
    logic q_valid, q_pop;
    logic [160:0] d;

    // unpack input item
    always_comb begin
        in_cmd.clear = s_tuser;
        in_cmd.sx = s_tdata[31:0];    in_cmd.sy = s_tdata[63:32];
        in_cmd.sz = s_tdata[95:64];   in_cmd.ex = s_tdata[127:96];
        in_cmd.ey = s_tdata[159:128]; in_cmd.ez = s_tdata[191:160];
        in_cmd.w  = s_tdata[223:192]; in_cmd.rgba = s_tdata[255:224];
    end

    lqe_front u_front (.aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd, .q_valid, .q_pop, .q_cmd);
    lqe_back u_back (.aclk, .aresetn, .q_valid, .q_pop, .q_cmd,
        .m_valid(m_tvalid), .m_ready(m_tready), .m_data(d), .m_last(m_tlast));

    assign m_tuser = d[0];
    assign m_tdata = d[160:1];
endmodule
`default_nettype wire

@@ src/lqe_checker.sv @@
// port checker for the line to quad expander
// depends on line_to_quad_expand_defines.svh
`default_nettype none
`include "line_to_quad_expand_defines.svh"
module lqe_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [159:0] m_tdata,
    input wire         m_tuser,
    input wire         m_tlast
);
    `LQE_ASSERT(a_last_is_index, !(m_tvalid && m_tlast) || m_tuser)
    `LQE_ASSERT(a_vert_no_index, !(m_tvalid && !m_tuser) || m_tdata[159:128] == 32'd0)
    `LQE_ASSERT(a_index_no_pos, !(m_tvalid && m_tuser) || m_tdata[127:0] == 128'd0)
    `LQE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid)
    `LQE_ASSERT_NEXT(a_data_stable, m_tvalid && !m_tready, $stable(m_tdata))
endmodule
bind line_to_quad_expand lqe_checker u_chk (.aclk, .aresetn, .m_tvalid, .m_tready,
    .m_tdata, .m_tuser, .m_tlast);
`default_nettype wire
